>>> hdl/lsbx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsbx_pkg;

  // beat payload widths
  localparam int PIXEL_W  = 8;
  localparam int SECRET_W = 8;

  // configuration port
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;
  localparam int LIMIT_W    = 27;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LEN   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEN_LIMIT = 2'd3;

  // register reset values
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 27'd104857600;

  // extraction counters
  localparam int POS_W  = 28;
  localparam int SLEN_W = 32;
  localparam int HEADER_BYTES = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  // extraction phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_IDLE    = 3'b100
  } phase_t;

endpackage

`default_nettype wire

>>> hdl/lsbx_if.sv
`timescale 1ns / 1ps
`default_nettype none

// pixel stream channel
interface lsbx_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [lsbx_pkg::PIXEL_W-1:0]  pixel_byte;
  logic                          first_of_image;

  modport source (output valid, output pixel_byte, output first_of_image, input ready);
  modport sink (input valid, input pixel_byte, input first_of_image, output ready);
endinterface

// secret result channel
interface lsbx_result_if;
  logic                          valid;
  logic                          ready;
  logic [lsbx_pkg::SECRET_W-1:0] secret_byte;
  logic                          last_byte;
  lsbx_pkg::status_t             status;

  modport source (output valid, output secret_byte, output last_byte, output status,
                  input ready);
  modport sink (input valid, input secret_byte, input last_byte, input status,
                output ready);
endinterface

`default_nettype wire

>>> hdl/lsb_extract_xor_payload.sv
`timescale 1ns / 1ps
`default_nettype none

// LSB extractor with XOR payload decryption. One pixel beat is taken every
// clock cycle; bit 0 of each pixel is gathered LSB first into bytes, each byte
// is XORed with a repeating key byte and with the low 8 bits of its position.
// The first four bytes are the little-endian secret length: above the limit
// gives one status-2 result, zero gives one status-1 result, otherwise every
// secret byte comes out with the last one marked. A result appears on the
// result channel in the cycle after the pixel beat that completes it and waits
// in a single output register; the pixel channel stalls only while that
// register is full and not being taken. After the end or an error, pixels are
// dropped until a beat with first_of_image set. Configuration writes are
// taken at any time and apply from the next completed byte.
module lsb_extract_xor_payload #(
  parameter int KEY_BYTES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  lsbx_pixel_if.sink                             pixels,
  lsbx_result_if.source                          results,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lsbx_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [lsbx_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam int KPW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [lsbx_pkg::KEY_LEN_W-1:0] KEY_MAX = lsbx_pkg::KEY_LEN_W'(KEY_BYTES);

  // configuration registers
  logic [7:0]                       key_mem [KEY_BYTES];
  logic [lsbx_pkg::KEY_LEN_W-1:0]   key_length;
  logic [lsbx_pkg::LIMIT_W-1:0]     length_limit;

  // extraction state
  lsbx_pkg::phase_t                 phase;
  logic [2:0]                       bit_count;
  logic [7:0]                       byte_gather;
  logic [lsbx_pkg::POS_W-1:0]       byte_position;
  logic [KPW-1:0]                   key_position;
  logic [lsbx_pkg::SLEN_W-1:0]      secret_length;

  // result register
  logic                             res_valid;
  logic [lsbx_pkg::SECRET_W-1:0]    res_byte;
  logic                             res_last;
  lsbx_pkg::status_t                res_status;

  // next values
  lsbx_pkg::phase_t                 phase_next;
  logic [2:0]                       bit_count_next;
  logic [7:0]                       byte_gather_next;
  logic [lsbx_pkg::POS_W-1:0]       byte_position_next;
  logic [KPW-1:0]                   key_position_next;
  logic [lsbx_pkg::SLEN_W-1:0]      secret_length_next;
  logic                             load_res;
  logic [lsbx_pkg::SECRET_W-1:0]    res_byte_next;
  logic                             res_last_next;
  lsbx_pkg::status_t                res_status_next;

  logic accept;

  assign pixels.ready = !res_valid || results.ready;
  assign accept       = pixels.valid && pixels.ready;

  assign results.valid       = res_valid;
  assign results.secret_byte = res_byte;
  assign results.last_byte   = res_last;
  assign results.status      = res_status;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < KEY_BYTES; b++) begin
        key_mem[b] <= 8'h00;
      end
      key_length   <= lsbx_pkg::KEY_LEN_RESET;
      length_limit <= lsbx_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsbx_pkg::REG_KEY_LOW: begin
          for (int b = 0; b < KEY_BYTES; b++) begin
            if (b < 8) key_mem[b] <= cfg_wr_data[8*(b%8) +: 8];
          end
        end
        lsbx_pkg::REG_KEY_HIGH: begin
          for (int b = 0; b < KEY_BYTES; b++) begin
            if (b >= 8) key_mem[b] <= cfg_wr_data[8*(b%8) +: 8];
          end
        end
        lsbx_pkg::REG_KEY_LEN: begin
          key_length <= cfg_wr_data[lsbx_pkg::KEY_LEN_W-1:0];
        end
        lsbx_pkg::REG_LEN_LIMIT: begin
          length_limit <= cfg_wr_data[lsbx_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // per-beat extraction step
  always_comb begin
    lsbx_pkg::phase_t                 cur_phase;
    logic [2:0]                       cur_bc;
    logic [7:0]                       cur_gather;
    logic [lsbx_pkg::POS_W-1:0]       cur_pos;
    logic [KPW-1:0]                   cur_kp;
    logic [lsbx_pkg::SLEN_W-1:0]      cur_slen;
    logic [7:0]                       gathered;
    logic [7:0]                       value;
    logic [lsbx_pkg::KEY_LEN_W-1:0]   klen;
    logic [lsbx_pkg::KEY_LEN_W-1:0]   kp_inc;
    logic [lsbx_pkg::SLEN_W-1:0]      slen_full;
    logic [lsbx_pkg::SLEN_W-1:0]      payload_idx;

    // restart on first of image
    if (pixels.first_of_image) begin
      cur_phase  = lsbx_pkg::PH_HEADER;
      cur_bc     = 3'd0;
      cur_gather = 8'h00;
      cur_pos    = '0;
      cur_kp     = '0;
      cur_slen   = '0;
    end else begin
      cur_phase  = phase;
      cur_bc     = bit_count;
      cur_gather = byte_gather;
      cur_pos    = byte_position;
      cur_kp     = key_position;
      cur_slen   = secret_length;
    end

    gathered = cur_gather | (8'(pixels.pixel_byte[0]) << cur_bc);
    value    = gathered ^ key_mem[cur_kp] ^ cur_pos[7:0];

    // effective key length, clamped to 1..KEY_BYTES
    if (key_length == '0) klen = lsbx_pkg::KEY_LEN_W'(1);
    else if (key_length > KEY_MAX) klen = KEY_MAX;
    else klen = key_length;
    kp_inc = lsbx_pkg::KEY_LEN_W'(cur_kp) + lsbx_pkg::KEY_LEN_W'(1);

    slen_full   = cur_slen | (lsbx_pkg::SLEN_W'(value) << {cur_pos[1:0], 3'b000});
    payload_idx = lsbx_pkg::SLEN_W'(cur_pos) - lsbx_pkg::SLEN_W'(lsbx_pkg::HEADER_BYTES - 1);

    phase_next         = cur_phase;
    bit_count_next     = cur_bc;
    byte_gather_next   = cur_gather;
    byte_position_next = cur_pos;
    key_position_next  = cur_kp;
    secret_length_next = cur_slen;
    load_res           = 1'b0;
    res_byte_next      = '0;
    res_last_next      = 1'b1;
    res_status_next    = lsbx_pkg::ST_DATA;

    if (cur_phase != lsbx_pkg::PH_IDLE) begin
      if (cur_bc != 3'd7) begin
        bit_count_next   = cur_bc + 3'd1;
        byte_gather_next = gathered;
      end else begin
        // full byte gathered
        bit_count_next     = 3'd0;
        byte_gather_next   = 8'h00;
        byte_position_next = cur_pos + lsbx_pkg::POS_W'(1);
        key_position_next  = (kp_inc >= klen) ? '0 : KPW'(kp_inc);

        if (cur_phase == lsbx_pkg::PH_HEADER) begin
          secret_length_next = slen_full;
          if (cur_pos >= lsbx_pkg::POS_W'(lsbx_pkg::HEADER_BYTES - 1)) begin
            if (slen_full > lsbx_pkg::SLEN_W'(length_limit)) begin
              phase_next      = lsbx_pkg::PH_IDLE;
              load_res        = 1'b1;
              res_status_next = lsbx_pkg::ST_OVER;
            end else if (slen_full == '0) begin
              phase_next      = lsbx_pkg::PH_IDLE;
              load_res        = 1'b1;
              res_status_next = lsbx_pkg::ST_DONE;
            end else begin
              phase_next = lsbx_pkg::PH_PAYLOAD;
            end
          end
        end else begin
          // secret byte
          load_res      = 1'b1;
          res_byte_next = value;
          res_last_next = (payload_idx >= cur_slen);
          if (payload_idx >= cur_slen) phase_next = lsbx_pkg::PH_IDLE;
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lsbx_pkg::PH_HEADER;
      bit_count     <= 3'd0;
      byte_gather   <= 8'h00;
      byte_position <= '0;
      key_position  <= '0;
      secret_length <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      byte_gather   <= byte_gather_next;
      byte_position <= byte_position_next;
      key_position  <= key_position_next;
      secret_length <= secret_length_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && load_res) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept && load_res) begin
      res_byte   <= res_byte_next;
      res_last   <= res_last_next;
      res_status <= res_status_next;
    end
  end

`ifndef SYNTHESIS
  // status results carry the end mark and a zero byte
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != lsbx_pkg::ST_DATA |-> res_last && res_byte == '0)
    else $error("status result without end mark");

  // a finished image leaves no partial byte behind
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == lsbx_pkg::PH_IDLE |-> bit_count == 3'd0 && byte_gather == 8'h00)
    else $error("partial byte left in idle phase");

  // the payload phase always has a nonzero secret length
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == lsbx_pkg::PH_PAYLOAD |-> secret_length != '0)
    else $error("payload phase with zero length");

  // loading a final result ends the image
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    accept && load_res && res_last_next |=> phase == lsbx_pkg::PH_IDLE)
    else $error("final result did not end extraction");
`endif

endmodule

`default_nettype wire
